@@ hw/rtl/rc4_stream_cipher_macros.svh @@
// ----------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Shorthand for clocked implication checks; clk and rst come from the
// enclosing scope.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// same-cycle implication
`define RC4_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rc4 check failed");

// next-cycle implication
`define RC4_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rc4 check failed");

`endif

@@ hw/rtl/rc4_pkg.sv @@
// ----------------------------------------------------------------------------
// RC4 package
// Sizes, operation codes and sequencer states shared by the RC4 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  localparam int KEY_DEPTH  = 256;
  localparam int KEY_AW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int TABLE_SIZE = 256;
  localparam int TABLE_AW   = 8;
  localparam int BYTE_W     = 8;
  localparam int KEY_LEN_W  = 9;
  localparam int OP_W       = 2;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_KEY = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_CIPHER   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CI_J,
    ST_CI_SWAP,
    ST_CI_OUT,
    ST_KS_READ,
    ST_KS_MIX,
    ST_KS_WN,
    ST_KS_WA
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/rc4_stream_cipher.sv @@
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Key store, key schedule and keystream XOR around one state-table RAM.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata / data              | tuser
//  s_axis   | in        | [7:0] key_position,       | [1:0] operation
//           |           | [15:8] value              |
//  m_axis   | out       | [7:0] out_byte            | -
//  cfg      | in        | [8:0] key_length          | -
//
//  Load key byte: written on accept. Cipher byte: accept, then the J,
//  swap and output states, set by the single read and single write port
//  of the state-table RAM. Key schedule: 4 RAM steps per swap, 256 swaps.
//  Reset: the state table reads as identity through per-entry valid bits;
//  no clearing pass. A waiting result holds in the output register; the
//  next cipher byte stalls in its last cycle until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] key_position, [15:8] value
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data       // [8:0] key_length
);

  localparam int TAW = rc4_pkg::TABLE_AW;
  localparam int KAW = rc4_pkg::KEY_AW;
  localparam int BW  = rc4_pkg::BYTE_W;
  localparam int LW  = rc4_pkg::KEY_LEN_W;

  rc4_pkg::state_t state, state_next;

  logic [BW-1:0]  key_position, value;
  rc4_pkg::op_t   operation;

  logic [TAW-1:0] idx_i, idx_i_next, idx_j, idx_j_next;
  logic [LW-1:0]  key_len;
  logic           out_valid;
  logic [BW-1:0]  out_data;

  logic [BW-1:0]  si, sj, sn, acc, acc_next, data_q, ks;
  logic [TAW-1:0] ks_addr, n;
  logic [KAW-1:0] kpos;

  logic           p_we, pv_clear, pv_q, out_load, k_we, pos_ok, kpos_wrap;
  logic [TAW-1:0] p_waddr, p_raddr, p_raddr_q;
  logic [BW-1:0]  p_wdata, p_rdata, perm_rd, k_rdata;
  logic [KAW-1:0] k_waddr;
  logic [LW-1:0]  len_eff, kpos_inc;
  logic [rc4_pkg::TABLE_SIZE-1:0] pvalid;

  assign key_position = s_axis_tdata[7:0];
  assign value        = s_axis_tdata[15:8];
  assign operation    = rc4_pkg::op_t'(s_axis_tuser);
  assign cfg_ready    = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign perm_rd = pv_q ? p_rdata : p_raddr_q;
  assign pos_ok  = LW'(key_position) < LW'(rc4_pkg::KEY_DEPTH);
  assign k_waddr = key_position[KAW-1:0];

  always_comb begin
    if (key_len == '0) begin
      len_eff = LW'(1);
    end else if (key_len > LW'(rc4_pkg::KEY_DEPTH)) begin
      len_eff = LW'(rc4_pkg::KEY_DEPTH);
    end else begin
      len_eff = key_len;
    end
  end

  assign kpos_inc  = LW'(kpos) + LW'(1);
  assign kpos_wrap = kpos_inc >= len_eff;
  assign acc_next  = acc + perm_rd + k_rdata;

  // forward the swap that is still being written
  always_comb begin
    if (ks_addr == idx_j) begin
      ks = si;
    end else if (ks_addr == idx_i) begin
      ks = sj;
    end else begin
      ks = perm_rd;
    end
  end

  rc4_ram #(.WIDTH(BW), .DEPTH(rc4_pkg::TABLE_SIZE)) u_perm (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(.WIDTH(BW), .DEPTH(rc4_pkg::KEY_DEPTH)) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (value),
    .raddr (kpos),
    .rdata (k_rdata)
  );

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    p_we          = 1'b0;
    p_waddr       = idx_i;
    p_wdata       = sj;
    p_raddr       = idx_i + TAW'(1);
    k_we          = 1'b0;
    pv_clear      = 1'b0;
    out_load      = 1'b0;
    idx_i_next    = idx_i;
    idx_j_next    = idx_j;
    case (state)
      rc4_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (operation)
            rc4_pkg::OP_LOAD_KEY: begin
              k_we = pos_ok;
            end
            rc4_pkg::OP_SCHEDULE: begin
              pv_clear   = 1'b1;
              state_next = rc4_pkg::ST_KS_READ;
            end
            rc4_pkg::OP_CIPHER: begin
              idx_i_next = idx_i + TAW'(1);
              state_next = rc4_pkg::ST_CI_J;
            end
            default: begin
            end
          endcase
        end
      end
      rc4_pkg::ST_CI_J: begin
        idx_j_next = idx_j + perm_rd;
        p_raddr    = idx_j + perm_rd;
        state_next = rc4_pkg::ST_CI_SWAP;
      end
      rc4_pkg::ST_CI_SWAP: begin
        p_we       = 1'b1;
        p_waddr    = idx_i;
        p_wdata    = perm_rd;
        p_raddr    = si + perm_rd;
        state_next = rc4_pkg::ST_CI_OUT;
      end
      rc4_pkg::ST_CI_OUT: begin
        p_we    = 1'b1;
        p_waddr = idx_j;
        p_wdata = si;
        p_raddr = ks_addr;
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_KS_READ: begin
        p_raddr    = n;
        state_next = rc4_pkg::ST_KS_MIX;
      end
      rc4_pkg::ST_KS_MIX: begin
        p_raddr    = acc_next;
        state_next = rc4_pkg::ST_KS_WN;
      end
      rc4_pkg::ST_KS_WN: begin
        p_we       = 1'b1;
        p_waddr    = n;
        p_wdata    = perm_rd;
        state_next = rc4_pkg::ST_KS_WA;
      end
      rc4_pkg::ST_KS_WA: begin
        p_we    = 1'b1;
        p_waddr = acc;
        p_wdata = sn;
        if (n == TAW'(rc4_pkg::TABLE_SIZE - 1)) begin
          idx_i_next = '0;
          idx_j_next = '0;
          state_next = rc4_pkg::ST_IDLE;
        end else begin
          state_next = rc4_pkg::ST_KS_READ;
        end
      end
      default: begin
        state_next = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rc4_pkg::ST_IDLE;
      idx_i     <= '0;
      idx_j     <= '0;
      key_len   <= rc4_pkg::KEY_LEN_RESET;
      out_valid <= 1'b0;
      pvalid    <= '0;
    end else begin
      state <= state_next;
      idx_i <= idx_i_next;
      idx_j <= idx_j_next;
      if (cfg_valid) begin
        key_len <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (pv_clear) begin
        pvalid <= '0;
      end else if (p_we) begin
        pvalid[p_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pv_q      <= pvalid[p_raddr];
    p_raddr_q <= p_raddr;
    if (out_load) begin
      out_data <= data_q ^ ks;
    end
    case (state)
      rc4_pkg::ST_IDLE: begin
        data_q <= value;
        n      <= '0;
        kpos   <= '0;
        acc    <= '0;
      end
      rc4_pkg::ST_CI_J: begin
        si <= perm_rd;
      end
      rc4_pkg::ST_CI_SWAP: begin
        sj      <= perm_rd;
        ks_addr <= si + perm_rd;
      end
      rc4_pkg::ST_KS_MIX: begin
        sn  <= perm_rd;
        acc <= acc_next;
      end
      rc4_pkg::ST_KS_WA: begin
        n    <= n + TAW'(1);
        kpos <= kpos_wrap ? '0 : kpos_inc[KAW-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/rc4_ram.sv @@
// ----------------------------------------------------------------------------
// RC4 generic RAM
// One write port, one read port, registered read data (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/rc4_checker.sv @@
// ----------------------------------------------------------------------------
// RC4 port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rc4_stream_cipher_macros.svh"

module rc4_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  logic s_acc, s_busy_op, s_load_op, m_stall;

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign s_busy_op = (s_axis_tuser == rc4_pkg::OP_SCHEDULE) ||
                     (s_axis_tuser == rc4_pkg::OP_CIPHER);
  assign s_load_op = s_axis_tuser == rc4_pkg::OP_LOAD_KEY;
  assign m_stall   = m_axis_tvalid && !m_axis_tready;

  `RC4_ASSERT_NXT(a_out_hold, m_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `RC4_ASSERT_NXT(a_busy_after_work, s_acc && s_busy_op, !s_axis_tready)
  `RC4_ASSERT_NXT(a_load_one_cycle, s_acc && s_load_op, s_axis_tready)
  `RC4_ASSERT_IMP(a_result_after_work, $rose(m_axis_tvalid), !$past(s_axis_tready))
  `RC4_ASSERT_IMP(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

`default_nettype wire
